FILE: src/ghash_pkg.sv
// ghash_pkg: shared types and constants for the GHASH accumulator.
// Used by ghash_digit_step, ghash_accumulator, ghash_chk and tb_top; no dependencies.
package ghash_pkg;

    localparam int HALF_W  = 64;
    localparam int BLOCK_W = 2 * HALF_W;

    // Bits of the multiplier operand consumed per pass through the step unit.
    localparam int DIGIT_W = 16;

    // Reduction byte: x^128 = x^7 + x^2 + x + 1, in GCM (reflected) bit order.
    localparam logic [7:0] GF_POLY_TOP = 8'he1;

    localparam int CFG_INDEX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 1'b1;

    typedef struct packed {
        logic [HALF_W-1:0] block_high;
        logic [HALF_W-1:0] block_low;
        logic              first_block;
        logic              last_block;
    } t_in_word;

    typedef struct packed {
        logic [HALF_W-1:0] digest_high;
        logic [HALF_W-1:0] digest_low;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_HOLD
    } t_state;

endpackage

FILE: src/ghash_digit_step.sv
// ghash_digit_step: one digit of the GF(2^128) shift-and-add multiply.
// Depends on ghash_pkg for widths and the reduction constant.
module ghash_digit_step #(
    parameter int DIGIT_W = ghash_pkg::DIGIT_W
) (
    input  logic [ghash_pkg::BLOCK_W-1:0] i_r,
    input  logic [ghash_pkg::BLOCK_W-1:0] i_v,
    input  logic [DIGIT_W-1:0]            i_digit,
    output logic [ghash_pkg::BLOCK_W-1:0] o_r,
    output logic [ghash_pkg::BLOCK_W-1:0] o_v
);
    import ghash_pkg::*;

    // Most significant digit bit first: it is the lower-order coefficient.
    always_comb begin
        logic [BLOCK_W-1:0] r;
        logic [BLOCK_W-1:0] v;
        r = i_r;
        v = i_v;
        for (int k = 0; k < DIGIT_W; k++) begin
            if (i_digit[DIGIT_W-1-k]) begin
                r = r ^ v;
            end
            // multiply v by x: shift toward bit 0, fold the dropped x^127 term back
            v = {1'b0, v[BLOCK_W-1:1]}
                ^ (v[0] ? {GF_POLY_TOP, {(BLOCK_W-8){1'b0}}} : {BLOCK_W{1'b0}});
        end
        o_r = r;
        o_v = v;
    end

endmodule

FILE: src/ghash_accumulator.sv
// ghash_accumulator: GCM GHASH accumulator, Y = (Y xor X) * H in GF(2^128).
// Depends on ghash_pkg and ghash_digit_step.
//
//   channel | direction | handshake                 | word
//   --------+-----------+---------------------------+------------------------------------
//   in      | sink      | i_in_valid / o_in_ready   | i_in_data  (t_in_word)
//   out     | source    | o_out_valid / i_out_ready | o_out_data (t_out_word)
//   cfg     | sink      | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data (64 bits)
//
// Each block is accepted in ST_IDLE, then takes one pass per digit in ST_MUL
// through the shared digit-step multiplier, which bounds the rate.
// The accumulator feeds the next block.
// A digest sits in an output register; the next block is accepted while it waits.
// If a new digest finishes while the old one is still unread, hold in ST_HOLD.
// Synchronous active-low reset clears the key, the accumulator, the state and the output valid flag.
// The config port is always ready; write it only while the block is idle.
module ghash_accumulator #(
    // must divide 128; range 1 to 64
    parameter int DIGIT_W = ghash_pkg::DIGIT_W
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  ghash_pkg::t_in_word               i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output ghash_pkg::t_out_word              o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ghash_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [ghash_pkg::HALF_W-1:0]      i_cfg_data
);
    import ghash_pkg::*;

    localparam int NUM_STEPS = BLOCK_W / DIGIT_W;
    localparam int CNT_W     = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_STEPS - 1);

    t_state             r_state;
    t_state             n_state;
    logic [BLOCK_W-1:0] r_key;
    logic [BLOCK_W-1:0] r_acc;
    logic [BLOCK_W-1:0] r_x;     // multiplier operand, consumed from the top
    logic [BLOCK_W-1:0] r_r;     // running product
    logic [BLOCK_W-1:0] r_v;     // H times the current power of x
    logic [CNT_W-1:0]   r_count;
    logic               r_last;
    logic               r_out_valid;
    t_out_word          r_out;

    logic [BLOCK_W-1:0] w_r_next;
    logic [BLOCK_W-1:0] w_v_next;
    logic               w_in_acc;
    logic               w_out_free;
    logic               w_finish;
    logic               w_out_from_mul;
    logic               w_out_from_acc;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    ghash_digit_step #(
        .DIGIT_W (DIGIT_W)
    ) u_step (
        .i_r     (r_r),
        .i_v     (r_v),
        .i_digit (r_x[BLOCK_W-1 -: DIGIT_W]),
        .o_r     (w_r_next),
        .o_v     (w_v_next)
    );

    // Sequencer: next state and load strobes.
    always_comb begin
        n_state        = r_state;
        w_finish       = 1'b0;
        w_out_from_mul = 1'b0;
        w_out_from_acc = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                if (r_count == LAST_CNT) begin
                    w_finish = 1'b1;
                    if (r_last && !w_out_free) begin
                        n_state = ST_HOLD;
                    end else begin
                        w_out_from_mul = r_last;
                        n_state        = ST_IDLE;
                    end
                end
            end
            ST_HOLD: begin
                if (w_out_free) begin
                    w_out_from_acc = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hash subkey registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_KEY_HIGH: r_key[BLOCK_W-1:HALF_W] <= i_cfg_data;
                REG_KEY_LOW:  r_key[HALF_W-1:0]       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Accumulator: take the finished product at the end of the last digit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (w_finish) begin
            r_acc <= w_r_next;
        end
    end

    // Multiply datapath: load on accept, advance one digit per cycle.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_x     <= (i_in_data.first_block ? {BLOCK_W{1'b0}} : r_acc)
                       ^ {i_in_data.block_high, i_in_data.block_low};
            r_r     <= '0;
            r_v     <= r_key;
            r_count <= '0;
            r_last  <= i_in_data.last_block;
        end else if (r_state == ST_MUL) begin
            r_x     <= r_x << DIGIT_W;
            r_r     <= w_r_next;
            r_v     <= w_v_next;
            r_count <= r_count + 1'b1;
        end
    end

    // Output register: hold the digest until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_from_mul || w_out_from_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_from_mul) begin
            r_out <= '{digest_high: w_r_next[BLOCK_W-1:HALF_W],
                       digest_low:  w_r_next[HALF_W-1:0]};
        end else if (w_out_from_acc) begin
            r_out <= '{digest_high: r_acc[BLOCK_W-1:HALF_W],
                       digest_low:  r_acc[HALF_W-1:0]};
        end
    end

endmodule

FILE: src/ghash_chk.sv
// ghash_chk: port-level assertions for ghash_accumulator, bound into every ghash_accumulator.
// Depends on ghash_pkg for the word types.
module ghash_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input ghash_pkg::t_out_word o_out_data
);

    // Reset empties the output and leaves the block ready.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("ghash_chk: bad state after reset");

    // A stalled digest stays valid.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("ghash_chk: digest dropped while stalled");

    // A stalled digest keeps its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("ghash_chk: digest changed while stalled");

    // An accepted word keeps the block busy on the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ghash_chk: ready right after accept");

    // A digest only appears after multiplier work, never straight out of the idle state.
    a_out_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) && $past(i_rst_n) |-> $past(!o_in_ready))
        else $error("ghash_chk: digest without a multiply");

endmodule

bind ghash_accumulator ghash_chk u_ghash_chk (.*);

FILE: test/tb_top.sv
// tb_top: self-checking bench for the GHASH accumulator.
// Depends on ghash_pkg (word types, register indexes, reduction byte) and ghash_accumulator.
`timescale 1ns / 100ps

module tb_top;

    import ghash_pkg::*;

    localparam int SETTLE_CYCLES = 24;      // leave margin for the last block to finish
    localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
    localparam int CYCLE_LIMIT   = 200000;  // generous watchdog
    localparam int PHASE_BLOCKS  = 50;
    localparam int NUM_PHASES    = 8;

    logic                   i_clk;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_ready;
    t_in_word               i_in_data   = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    t_out_word              o_out_data;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = REG_KEY_HIGH;
    logic [HALF_W-1:0]      i_cfg_data  = '0;

    // Predictor state: running hash value and subkey, both start at zero as after reset.
    logic [BLOCK_W-1:0] running_hash = '0;
    logic [BLOCK_W-1:0] subkey       = '0;

    t_in_word  pending_blocks[$];
    t_out_word expected_digests[$];

    int  sender_gap_pct = 0;
    int  stall_pct      = 0;
    bit  receiver_hold  = 1'b0;
    int  error_count    = 0;
    int  cycle_count    = 0;
    event hold_go;

    ghash_accumulator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // GF(2^128) product in GCM bit order: bit 127 of the vector is x^0.
    // Walk the multiplier from x^0 upward, halving the shifted subkey each step
    // and folding the bit that drops off x^127 back in through the reduction byte.
    function automatic logic [BLOCK_W-1:0] ghash_mul(input logic [BLOCK_W-1:0] x,
                                                     input logic [BLOCK_W-1:0] h);
        logic [BLOCK_W-1:0] prod;
        logic [BLOCK_W-1:0] v;
        logic               lsb;
        prod = '0;
        v    = h;
        for (int i = BLOCK_W - 1; i >= 0; i--) begin
            if (x[i]) prod ^= v;
            lsb = v[0];
            v   = v >> 1;
            if (lsb) v[BLOCK_W-1 -: 8] ^= GF_POLY_TOP;
        end
        return prod;
    endfunction

    // Fold one accepted word into the running hash; queue a digest on a last block.
    function automatic void absorb_block(input t_in_word w);
        logic [BLOCK_W-1:0] operand;
        t_out_word          dg;
        operand      = (w.first_block ? '0 : running_hash) ^ {w.block_high, w.block_low};
        running_hash = ghash_mul(operand, subkey);
        if (w.last_block) begin
            dg.digest_high = running_hash[BLOCK_W-1:HALF_W];
            dg.digest_low  = running_hash[HALF_W-1:0];
            expected_digests.push_back(dg);
        end
    endfunction

    // Random half with extra weight on all-zero, all-one and single-bit values.
    function automatic logic [HALF_W-1:0] rand_half();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 64'd1 << $urandom_range(0, HALF_W - 1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Subkey picks: zero, all ones, the field's unit (x^0 alone), x^127 alone, random.
    function automatic logic [BLOCK_W-1:0] pick_subkey();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return {64'h8000_0000_0000_0000, 64'd0};
            3:       return {64'd0, 64'd1};
            default: return {rand_half(), rand_half()};
        endcase
    endfunction

    function automatic void queue_block(input logic [HALF_W-1:0] hi, input logic [HALF_W-1:0] lo,
                                        input logic first, input logic last);
        t_in_word w;
        w.block_high  = hi;
        w.block_low   = lo;
        w.first_block = first;
        w.last_block  = last;
        pending_blocks.push_back(w);
    endfunction

    // Mostly well-formed messages (first on the opening word, last on the closing
    // one) of 1 to 6 blocks; about one in eight words gets random flags instead.
    function automatic void queue_random_blocks(input int count);
        int left;
        int msg_len;
        left = count;
        while (left > 0) begin
            msg_len = $urandom_range(1, 6);
            if (msg_len > left) msg_len = left;
            for (int k = 0; k < msg_len; k++) begin
                if ($urandom_range(0, 7) == 0)
                    queue_block(rand_half(), rand_half(), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)));
                else
                    queue_block(rand_half(), rand_half(), k == 0, k == msg_len - 1);
            end
            left -= msg_len;
        end
    endfunction

    // Write one key register; update the predictor's copy at the accepting edge.
    task automatic write_key_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [HALF_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_KEY_HIGH)
            subkey[BLOCK_W-1:HALF_W] = val;
        else
            subkey[HALF_W-1:0] = val;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_subkey(input logic [BLOCK_W-1:0] key);
        write_key_reg(REG_KEY_HIGH, key[BLOCK_W-1:HALF_W]);
        write_key_reg(REG_KEY_LOW, key[HALF_W-1:0]);
    endtask

    // Wait until every word is accepted and every digest is back, then let the
    // block finish any block that produces no digest.
    task automatic wait_quiet();
        @(negedge i_clk);
        while (pending_blocks.size() != 0 || i_in_valid || expected_digests.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Driver: present the next pending word once the current one is taken,
    // idling at random per the current gap percentage. Predict on acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) absorb_block(i_in_data);
            if (!i_in_valid || o_in_ready) begin
                if (pending_blocks.size() != 0 && $urandom_range(0, 99) >= sender_gap_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_blocks.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted digest word against the oldest expectation,
    // then choose the next ready value (stall at random, or hold during pressure).
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_digests.size() == 0) begin
                    $error("unexpected digest word %h_%h", o_out_data.digest_high,
                           o_out_data.digest_low);
                    error_count++;
                end else begin
                    want = expected_digests.pop_front();
                    if (o_out_data.digest_high !== want.digest_high) begin
                        $error("digest_high: expected %h, got %h", want.digest_high,
                               o_out_data.digest_high);
                        error_count++;
                    end
                    if (o_out_data.digest_low !== want.digest_low) begin
                        $error("digest_low: expected %h, got %h", want.digest_low,
                               o_out_data.digest_low);
                        error_count++;
                    end
                end
            end
            i_out_ready <= !receiver_hold && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Pressure: drop ready for a long stretch so the output register and the
    // hold state fill and the block stops taking input words.
    initial begin
        forever begin
            @(hold_go);
            receiver_hold = 1'b1;
            repeat (HOLD_CYCLES) @(negedge i_clk);
            receiver_hold = 1'b0;
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Stimulus sequence.
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Zero subkey straight out of reset, and a hash that never saw a
        // first flag: every digest must come back zero.
        queue_block('1, '1, 1'b0, 1'b1);
        queue_block(rand_half(), rand_half(), 1'b1, 1'b1);
        wait_quiet();

        // Unit subkey: the digest is the xor of the blocks. Also continue a
        // hash past a last block without a new first flag.
        write_subkey({64'h8000_0000_0000_0000, 64'd0});
        queue_block('1, '1, 1'b1, 1'b0);
        queue_block('0, '0, 1'b0, 1'b1);
        queue_block(rand_half(), rand_half(), 1'b0, 1'b1);
        wait_quiet();

        // All-ones subkey against all-ones, zero and single-term blocks, including
        // x^127, then an open hash of two random blocks.
        write_subkey('1);
        queue_block('1, '1, 1'b1, 1'b1);
        queue_block('0, '0, 1'b1, 1'b1);
        queue_block(64'h8000_0000_0000_0000, '0, 1'b1, 1'b1);
        queue_block(64'd1, '0, 1'b1, 1'b1);
        queue_block('0, 64'h8000_0000_0000_0000, 1'b1, 1'b1);
        queue_block('0, 64'd1, 1'b1, 1'b1);
        queue_block(rand_half(), rand_half(), 1'b1, 1'b0);
        queue_block(rand_half(), rand_half(), 1'b0, 1'b0);
        wait_quiet();

        // Change the key in the middle of an open hash, one half at a time.
        write_key_reg(REG_KEY_HIGH, rand_half());
        queue_block(rand_half(), rand_half(), 1'b0, 1'b0);
        wait_quiet();
        write_key_reg(REG_KEY_LOW, rand_half());
        queue_block(rand_half(), rand_half(), 1'b0, 1'b1);
        wait_quiet();

        // Random phases: no idling, sender gaps, receiver stalls, both.
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p % 2 == 0)
                write_subkey(pick_subkey());
            else
                write_key_reg($urandom_range(0, 1) ? REG_KEY_LOW : REG_KEY_HIGH, rand_half());
            case (p % 4)
                0: begin sender_gap_pct = 0;  stall_pct = 0;  end
                1: begin sender_gap_pct = 63; stall_pct = 0;  end
                2: begin sender_gap_pct = 0;  stall_pct = 63; end
                default: begin sender_gap_pct = 31; stall_pct = 31; end
            endcase
            queue_random_blocks(PHASE_BLOCKS);
            if (p == 4) -> hold_go;
            wait_quiet();
        end

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
